/* rtl/srb_pkg.sv */
// srb_pkg: shared types and constants of the sample ring buffer.
// Item structs, request and result codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package srb_pkg;

   // Fixed field widths of the item and register formats
   localparam int REQ_TYPE_W   = 2;
   localparam int SAMPLE_W     = 64;
   localparam int LIMIT_W      = 16;
   localparam int FILL_W       = 10;
   localparam int TOTAL_W      = 10;
   localparam int BYTE_W       = 8;
   localparam int SAMPLE_CFG_W = 4;
   localparam int CAP_CFG_W    = 11;
   localparam int CSR_DATA_W   = 11;

   localparam logic [SAMPLE_CFG_W-1:0] SAMPLE_CFG_RESET = 4'd1;
   localparam logic [CAP_CFG_W-1:0]    CAP_CFG_RESET    = 11'd1024;

   // Request kinds carried in req_type
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   // Result codes
   typedef enum logic [1:0] {
      RES_DONE   = 2'd0,
      RES_FULL   = 2'd1,
      RES_SAMPLE = 2'd2,
      RES_EMPTY  = 2'd3
   } res_code_type;

   // Configuration register indexes
   typedef enum logic {
      CSR_SAMPLE_BYTES   = 1'b0,
      CSR_CAPACITY_BYTES = 1'b1
   } csr_index_type;

   // Operand select of the shared remainder unit
   typedef enum logic [1:0] {
      DIV_WP  = 2'd0,
      DIV_RP  = 2'd1,
      DIV_LEN = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WP_CHK,
      ST_WP_DIV,
      ST_RP_CHK,
      ST_RP_DIV,
      ST_DISPATCH,
      ST_WR_CHK,
      ST_WRITE,
      ST_RD_LEN,
      ST_RD_DIV,
      ST_RD_SETUP,
      ST_RD_BYTE,
      ST_RD_DONE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [SAMPLE_W-1:0]   sample_data;
      logic [LIMIT_W-1:0]    read_limit_bytes;
   } req_item_type;

   typedef struct packed {
      logic [1:0]          result_code;
      logic [SAMPLE_W-1:0] read_sample;
      logic                last;
      logic [FILL_W-1:0]   fill_bytes;
      logic [TOTAL_W-1:0]  bytes_read_total;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic         latch;
      logic         div_start;
      div_sel_type  div_sel;
      logic         wp_fix;
      logic         rp_fix;
      logic         fill_load;
      logic         clear;
      logic         wr_begin;
      logic         wr_byte;
      logic         rd_size;
      logic         rd_begin;
      logic         rd_byte;
      logic         total_step;
      logic         emit;
      res_code_type code;
   } srb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_kind;
      logic                  wp_over;
      logic                  rp_over;
      logic                  div_done;
      logic                  wr_room;
      logic                  byte_final;
      logic                  bytes_zero;
      logic                  rd_last;
      logic                  out_free;
   } srb_status_type;

endpackage

`default_nettype wire

/* rtl/srb_ram.sv */
// srb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/srb_mod.sv */
// srb_mod: iterative remainder unit, one dividend bit per cycle (restoring).
// Used for position wrap and for whole-sample read length. No dependencies.
`default_nettype none

module srb_mod #(
   parameter int NUM_W = 10,
   parameter int DEN_W = 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [DEN_W-1:0] rem
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = DEN_W'(trial);
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

/* rtl/srb_datapath.sv */
// srb_datapath: positions, fill, config registers, byte store, remainder
// unit, sample assembly and result register. Depends on srb_pkg, srb_ram,
// srb_mod.
`default_nettype none

module srb_datapath #(
   parameter int BUF_BYTES        = 1024,
   parameter int MAX_SAMPLE_BYTES = 8,
   parameter int MAX_READ_SAMPLES = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire srb_pkg::srb_cmd_type            cmd,
   output srb_pkg::srb_status_type              st,
   input  wire srb_pkg::req_item_type           req_data,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output srb_pkg::rsp_item_type                rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire srb_pkg::csr_index_type          csr_index,
   input  wire logic [srb_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int PW   = $clog2(BUF_BYTES);
   localparam int CW   = $clog2(BUF_BYTES + 1);
   localparam int EW   = (CW > srb_pkg::CAP_CFG_W) ? CW : srb_pkg::CAP_CFG_W;
   localparam int SW   = $clog2(MAX_SAMPLE_BYTES + 1);
   localparam int BIW  = (MAX_SAMPLE_BYTES > 1) ? $clog2(MAX_SAMPLE_BYTES) : 1;
   localparam int MW   = $clog2(MAX_READ_SAMPLES * MAX_SAMPLE_BYTES + 1);
   localparam int DVW  = (PW > MW) ? PW : MW;

   // Config registers
   logic [srb_pkg::SAMPLE_CFG_W-1:0] sample_cfg_ff, sample_cfg_in;
   logic [srb_pkg::CAP_CFG_W-1:0]    cap_cfg_ff, cap_cfg_in;

   // Control and position registers
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          cap_valid_ff, cap_valid_in;

   // Payload registers
   srb_pkg::req_item_type                    req_ff, req_in;
   srb_pkg::rsp_item_type                    rsp_ff, rsp_in;
   logic [PW-1:0]                            fill_ff, fill_in;
   logic [PW-1:0]                            addr_ff, addr_in;
   logic [BIW-1:0]                           cnt_ff, cnt_in;
   logic [BIW-1:0]                           cap_idx_ff, cap_idx_in;
   logic [MW-1:0]                            m_ff, m_in;
   logic [MW-1:0]                            bytes_ff, bytes_in;
   logic [MW-1:0]                            total_ff, total_in;
   logic [MAX_SAMPLE_BYTES-1:0][srb_pkg::BYTE_W-1:0] asm_ff, asm_in;

   // Derived values
   logic [EW-1:0]               cap_ext;
   logic [CW-1:0]               cap_eff;
   logic [SW-1:0]               s_eff;
   logic [CW-1:0]               fill_calc;
   logic [PW-1:0]               addr_next;
   logic [MW-1:0]               max_len;
   logic [srb_pkg::LIMIT_W-1:0] len_min;
   logic [MW-1:0]               m_len;
   logic [DVW-1:0]              div_num;
   logic [CW-1:0]               div_den;
   logic                        div_done;
   logic [CW-1:0]               div_rem;
   logic                        ram_wr_en;
   logic [srb_pkg::BYTE_W-1:0]  ram_wr_data;
   logic [srb_pkg::BYTE_W-1:0]  ram_rd_data;
   logic                        out_free;

   // Effective register values, saturated to their legal ranges
   always_comb begin
      cap_ext = EW'(cap_cfg_ff);
      if (cap_ext < EW'(2)) begin
         cap_eff = CW'(2);
      end else if (cap_ext > EW'(BUF_BYTES)) begin
         cap_eff = CW'(BUF_BYTES);
      end else begin
         cap_eff = CW'(cap_ext);
      end
      if (sample_cfg_ff == '0) begin
         s_eff = SW'(1);
      end else if (sample_cfg_ff > srb_pkg::SAMPLE_CFG_W'(MAX_SAMPLE_BYTES)) begin
         s_eff = SW'(MAX_SAMPLE_BYTES);
      end else begin
         s_eff = SW'(sample_cfg_ff);
      end
   end

   // Fill from the two positions, and the next byte address with wrap
   always_comb begin
      if (wp_ff >= rp_ff) begin
         fill_calc = CW'(wp_ff - rp_ff);
      end else begin
         fill_calc = cap_eff - CW'(rp_ff) + CW'(wp_ff);
      end
      if (CW'(addr_ff) + CW'(1) == cap_eff) begin
         addr_next = '0;
      end else begin
         addr_next = addr_ff + PW'(1);
      end
   end

   // Read length: min of limit, fill and the per-request sample cap
   always_comb begin
      max_len = MW'(MAX_READ_SAMPLES) * MW'(s_eff);
      if (req_ff.read_limit_bytes < srb_pkg::LIMIT_W'(fill_ff)) begin
         len_min = req_ff.read_limit_bytes;
      end else begin
         len_min = srb_pkg::LIMIT_W'(fill_ff);
      end
      if (srb_pkg::LIMIT_W'(max_len) < len_min) begin
         len_min = srb_pkg::LIMIT_W'(max_len);
      end
      m_len = MW'(len_min);
   end

   // Remainder unit operands
   always_comb begin
      case (cmd.div_sel)
         srb_pkg::DIV_WP: begin
            div_num = DVW'(wp_ff);
            div_den = cap_eff;
         end
         srb_pkg::DIV_RP: begin
            div_num = DVW'(rp_ff);
            div_den = cap_eff;
         end
         srb_pkg::DIV_LEN: begin
            div_num = DVW'(m_len);
            div_den = CW'(s_eff);
         end
         default: begin
            div_num = '0;
            div_den = cap_eff;
         end
      endcase
   end

   srb_mod #(
      .NUM_W (DVW),
      .DEN_W (CW)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .rem   (div_rem)
   );

   // Byte store
   assign ram_wr_en   = cmd.wr_byte;
   assign ram_wr_data = req_ff.sample_data[{cnt_ff, 3'b000} +: srb_pkg::BYTE_W];

   srb_ram #(
      .WIDTH (srb_pkg::BYTE_W),
      .DEPTH (BUF_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Status to the controller
   always_comb begin
      st            = '0;
      st.req_kind   = req_ff.req_type;
      st.wp_over    = CW'(wp_ff) >= cap_eff;
      st.rp_over    = CW'(rp_ff) >= cap_eff;
      st.div_done   = div_done;
      st.wr_room    = (cap_eff - CW'(1) - CW'(fill_ff)) >= CW'(s_eff);
      st.byte_final = SW'(cnt_ff) == (s_eff - SW'(1));
      st.bytes_zero = bytes_ff == '0;
      st.rd_last    = total_ff == bytes_ff;
      st.out_free   = out_free;
   end

   // Next-state logic of the datapath registers
   always_comb begin
      sample_cfg_in = sample_cfg_ff;
      cap_cfg_in    = cap_cfg_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      rsp_valid_in  = rsp_valid_ff;
      cap_valid_in  = cmd.rd_byte;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      cap_idx_in    = cnt_ff;
      m_in          = m_ff;
      bytes_in      = bytes_ff;
      total_in      = total_ff;
      asm_in        = asm_ff;

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            srb_pkg::CSR_SAMPLE_BYTES:
               sample_cfg_in = srb_pkg::SAMPLE_CFG_W'(csr_data);
            srb_pkg::CSR_CAPACITY_BYTES:
               cap_cfg_in = srb_pkg::CAP_CFG_W'(csr_data);
            default: ;
         endcase
      end

      // request capture
      if (cmd.latch) begin
         req_in   = req_data;
         total_in = '0;
      end

      // read length capture, and position wrap after a capacity change
      if (cmd.div_start && cmd.div_sel == srb_pkg::DIV_LEN) begin
         m_in = m_len;
      end
      if (cmd.wp_fix) begin
         wp_in = PW'(div_rem);
      end
      if (cmd.rp_fix) begin
         rp_in = PW'(div_rem);
      end

      if (cmd.fill_load) begin
         fill_in = PW'(fill_calc);
      end
      if (cmd.clear) begin
         wp_in   = '0;
         rp_in   = '0;
         fill_in = '0;
      end

      // write path: one byte per cycle
      if (cmd.wr_begin) begin
         addr_in = wp_ff;
         cnt_in  = '0;
      end
      if (cmd.wr_byte) begin
         addr_in = addr_next;
         cnt_in  = cnt_ff + BIW'(1);
         if (st.byte_final) begin
            cnt_in  = '0;
            wp_in   = addr_next;
            fill_in = PW'(CW'(fill_ff) + CW'(s_eff));
         end
      end

      // read: whole-sample byte count; a byte per cycle within a sample
      if (cmd.rd_size) begin
         bytes_in = m_ff - MW'(div_rem);
      end
      if (cmd.rd_begin) begin
         fill_in  = fill_ff - PW'(bytes_ff);
         total_in = '0;
         addr_in  = rp_ff;
         cnt_in   = '0;
      end
      if (cmd.rd_byte) begin
         addr_in = addr_next;
         cnt_in  = cnt_ff + BIW'(1);
         if (cnt_ff == '0) begin
            asm_in = '0;
         end
         if (st.byte_final) begin
            cnt_in = '0;
            rp_in  = addr_next;
         end
      end
      if (cap_valid_ff) begin
         asm_in[cap_idx_ff] = ram_rd_data;
      end
      if (cmd.total_step) begin
         total_in = total_ff + MW'(s_eff);
      end

      // result register
      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_in.result_code      = cmd.code;
         rsp_in.fill_bytes       = srb_pkg::FILL_W'(fill_ff);
         rsp_in.bytes_read_total = srb_pkg::TOTAL_W'(total_ff);
         if (cmd.code == srb_pkg::RES_SAMPLE) begin
            rsp_in.read_sample = srb_pkg::SAMPLE_W'(asm_ff);
            rsp_in.last        = st.rd_last;
         end else begin
            rsp_in.read_sample = '0;
            rsp_in.last        = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_cfg_ff <= srb_pkg::SAMPLE_CFG_RESET;
         cap_cfg_ff    <= srb_pkg::CAP_CFG_RESET;
         wp_ff         <= '0;
         rp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         cap_valid_ff  <= 1'b0;
      end else begin
         sample_cfg_ff <= sample_cfg_in;
         cap_cfg_ff    <= cap_cfg_in;
         wp_ff         <= wp_in;
         rp_ff         <= rp_in;
         rsp_valid_ff  <= rsp_valid_in;
         cap_valid_ff  <= cap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      fill_ff    <= fill_in;
      addr_ff    <= addr_in;
      cnt_ff     <= cnt_in;
      cap_idx_ff <= cap_idx_in;
      m_ff       <= m_in;
      bytes_ff   <= bytes_in;
      total_ff   <= total_in;
      asm_ff     <= asm_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

`ifndef SYNTHESIS
   // a result is never loaded over one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result register overwritten");

   // store writes stay inside the ring in use
   a_wr_addr: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_byte |-> (CW'(addr_ff) < cap_eff))
      else $error("write address beyond capacity");

   // no byte is fetched once the whole-sample length is delivered
   a_rd_total: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_byte |-> (total_ff < bytes_ff))
      else $error("read past computed length");

   // fill is taken only from wrapped positions
   a_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_load |-> (fill_calc < cap_eff))
      else $error("fill not below capacity");
`endif

endmodule

`default_nettype wire

/* rtl/srb_ctrl.sv */
// srb_ctrl: request sequencer of the sample ring buffer. Drives the
// datapath by command struct and reads its status. Depends on srb_pkg.
`default_nettype none

module srb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output srb_pkg::srb_cmd_type         cmd,
   input  wire srb_pkg::srb_status_type st
);

   srb_pkg::state_type    state_ff, state_in;
   srb_pkg::res_code_type code_ff, code_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      case (state_ff)
         srb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = srb_pkg::ST_WP_CHK;
            end
         end
         // wrap positions left beyond a shrunk capacity
         srb_pkg::ST_WP_CHK: begin
            if (st.wp_over) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = srb_pkg::DIV_WP;
               state_in      = srb_pkg::ST_WP_DIV;
            end else begin
               state_in = srb_pkg::ST_RP_CHK;
            end
         end
         srb_pkg::ST_WP_DIV: begin
            if (st.div_done) begin
               cmd.wp_fix = 1'b1;
               state_in   = srb_pkg::ST_RP_CHK;
            end
         end
         srb_pkg::ST_RP_CHK: begin
            if (st.rp_over) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = srb_pkg::DIV_RP;
               state_in      = srb_pkg::ST_RP_DIV;
            end else begin
               state_in = srb_pkg::ST_DISPATCH;
            end
         end
         srb_pkg::ST_RP_DIV: begin
            if (st.div_done) begin
               cmd.rp_fix = 1'b1;
               state_in   = srb_pkg::ST_DISPATCH;
            end
         end
         srb_pkg::ST_DISPATCH: begin
            case (st.req_kind)
               srb_pkg::REQ_WRITE: begin
                  cmd.fill_load = 1'b1;
                  state_in      = srb_pkg::ST_WR_CHK;
               end
               srb_pkg::REQ_READ: begin
                  cmd.fill_load = 1'b1;
                  state_in      = srb_pkg::ST_RD_LEN;
               end
               srb_pkg::REQ_CLEAR: begin
                  cmd.clear = 1'b1;
                  code_in   = srb_pkg::RES_DONE;
                  state_in  = srb_pkg::ST_EMIT;
               end
               default: begin
                  state_in = srb_pkg::ST_IDLE;
               end
            endcase
         end
         srb_pkg::ST_WR_CHK: begin
            if (st.wr_room) begin
               cmd.wr_begin = 1'b1;
               state_in     = srb_pkg::ST_WRITE;
            end else begin
               code_in  = srb_pkg::RES_FULL;
               state_in = srb_pkg::ST_EMIT;
            end
         end
         srb_pkg::ST_WRITE: begin
            cmd.wr_byte = 1'b1;
            if (st.byte_final) begin
               code_in  = srb_pkg::RES_DONE;
               state_in = srb_pkg::ST_EMIT;
            end
         end
         srb_pkg::ST_RD_LEN: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = srb_pkg::DIV_LEN;
            state_in      = srb_pkg::ST_RD_DIV;
         end
         srb_pkg::ST_RD_DIV: begin
            if (st.div_done) begin
               cmd.rd_size = 1'b1;
               state_in    = srb_pkg::ST_RD_SETUP;
            end
         end
         srb_pkg::ST_RD_SETUP: begin
            if (st.bytes_zero) begin
               code_in  = srb_pkg::RES_EMPTY;
               state_in = srb_pkg::ST_EMIT;
            end else begin
               cmd.rd_begin = 1'b1;
               state_in     = srb_pkg::ST_RD_BYTE;
            end
         end
         srb_pkg::ST_RD_BYTE: begin
            cmd.rd_byte = 1'b1;
            if (st.byte_final) begin
               state_in = srb_pkg::ST_RD_DONE;
            end
         end
         // last byte lands in the sample register this cycle
         srb_pkg::ST_RD_DONE: begin
            cmd.total_step = 1'b1;
            code_in        = srb_pkg::RES_SAMPLE;
            state_in       = srb_pkg::ST_EMIT;
         end
         srb_pkg::ST_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (code_ff == srb_pkg::RES_SAMPLE && !st.rd_last) begin
                  state_in = srb_pkg::ST_RD_BYTE;
               end else begin
                  state_in = srb_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srb_pkg::ST_IDLE;
         code_ff  <= srb_pkg::RES_DONE;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready = (state_ff == srb_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* rtl/sample_ring_buffer.sv */
// Byte ring buffer of fixed-size samples, one item at a time. A write stores its
// sample a byte per cycle; a read first finds its whole-sample length with the
// 10-step bit-serial remainder, then gives one sample per result, each held
// until the result register is free. The next item is taken from the cycle after
// the last result; a position beyond a shrunk capacity is first wrapped by the
// remainder unit. Reset: positions zero, sample size 1, capacity 1024, store kept.
`default_nettype none

module sample_ring_buffer #(
   parameter int BUF_BYTES        = 1024,
   parameter int MAX_SAMPLE_BYTES = 8,
   parameter int MAX_READ_SAMPLES = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire srb_pkg::req_item_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output srb_pkg::rsp_item_type               rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire srb_pkg::csr_index_type         csr_index,
   input  wire logic [srb_pkg::CSR_DATA_W-1:0] csr_data
);

   srb_pkg::srb_cmd_type    cmd;
   srb_pkg::srb_status_type st;

   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   srb_datapath #(
      .BUF_BYTES        (BUF_BYTES),
      .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES),
      .MAX_READ_SAMPLES (MAX_READ_SAMPLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

/* bench/sample_ring_buffer_test.sv */
// sample_ring_buffer_test: self-checking bench for the sample ring buffer.
// Sends write/read/clear items and register writes, works out every result item
// from its own ring image and compares field by field. Needs srb_pkg and the RTL.
module sample_ring_buffer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_BYTES       = 1024;
   localparam int SAMPLE_MAX       = 8;
   localparam int READ_MAX_SAMPLES = 64;
   localparam int IDLE_PCT         = 34;
   localparam int SETTLE_CYCLES    = 64;
   localparam int CYCLE_LIMIT      = 1000000;
   // request code the block ignores
   localparam logic [srb_pkg::REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   srb_pkg::req_item_type          req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   srb_pkg::rsp_item_type          rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   srb_pkg::csr_index_type         csr_index = srb_pkg::CSR_SAMPLE_BYTES;
   logic [srb_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   // Ring image: store bytes, which addresses hold written data, positions, registers
   logic [srb_pkg::BYTE_W-1:0]       ring_mem  [RING_BYTES];
   bit                               ring_seen [RING_BYTES];
   int unsigned                      wr_ptr     = 0;
   int unsigned                      rd_ptr     = 0;
   logic [srb_pkg::SAMPLE_CFG_W-1:0] sample_reg = srb_pkg::SAMPLE_CFG_RESET;
   logic [srb_pkg::CAP_CFG_W-1:0]    cap_reg    = srb_pkg::CAP_CFG_RESET;

   srb_pkg::req_item_type req_backlog [$];
   srb_pkg::rsp_item_type answers_due [$];
   int           items_queued = 0;
   int           items_taken  = 0;
   int           fail_count   = 0;
   int           cycle_count  = 0;
   logic         req_fire     = 1'b0;
   bit           steady       = 1'b0;

   sample_ring_buffer #(
      .BUF_BYTES        (RING_BYTES),
      .MAX_SAMPLE_BYTES (SAMPLE_MAX),
      .MAX_READ_SAMPLES (READ_MAX_SAMPLES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Register values as the block uses them: saturated into range
   function automatic int unsigned sample_in_use();
      if (sample_reg < 1) return 1;
      if (sample_reg > SAMPLE_MAX) return SAMPLE_MAX;
      return 32'(sample_reg);
   endfunction

   function automatic int unsigned cap_in_use();
      if (cap_reg < 2) return 2;
      if (cap_reg > RING_BYTES) return RING_BYTES;
      return 32'(cap_reg);
   endfunction

   function automatic srb_pkg::rsp_item_type pack_rsp(srb_pkg::res_code_type code,
                                                      logic [srb_pkg::SAMPLE_W-1:0] smp,
                                                      logic lst, int unsigned fill,
                                                      int unsigned total);
      srb_pkg::rsp_item_type r;
      r.result_code      = code;
      r.read_sample      = smp;
      r.last             = lst;
      r.fill_bytes       = fill[srb_pkg::FILL_W-1:0];
      r.bytes_read_total = total[srb_pkg::TOTAL_W-1:0];
      return r;
   endfunction

   // Apply one accepted request to the ring image and queue the result items it owes
   task automatic ring_apply(srb_pkg::req_item_type item);
      int unsigned cap, s, fill, n, left, i, k;
      logic [srb_pkg::SAMPLE_W-1:0] word;
      cap    = cap_in_use();
      s      = sample_in_use();
      wr_ptr = wr_ptr % cap;
      rd_ptr = rd_ptr % cap;
      fill   = (wr_ptr + cap - rd_ptr) % cap;
      case (item.req_type)
         srb_pkg::REQ_WRITE: begin
            if (cap - 1 - fill < s) begin
               answers_due.push_back(pack_rsp(srb_pkg::RES_FULL, '0, 1'b1, fill, 0));
            end else begin
               for (i = 0; i < s; i++) begin
                  ring_mem[(wr_ptr + i) % cap]  = item.sample_data[8*i +: 8];
                  ring_seen[(wr_ptr + i) % cap] = 1'b1;
               end
               wr_ptr = (wr_ptr + s) % cap;
               answers_due.push_back(pack_rsp(srb_pkg::RES_DONE, '0, 1'b1, fill + s, 0));
            end
         end
         srb_pkg::REQ_READ: begin
            n = item.read_limit_bytes / s;
            if (fill / s < n) n = fill / s;
            if (n > READ_MAX_SAMPLES) n = READ_MAX_SAMPLES;
            if (n == 0) begin
               answers_due.push_back(pack_rsp(srb_pkg::RES_EMPTY, '0, 1'b1, fill, 0));
            end else begin
               left = fill - n * s;
               for (k = 0; k < n; k++) begin
                  word = '0;
                  for (i = 0; i < s; i++) begin
                     word[8*i +: 8] = ring_mem[(rd_ptr + i) % cap];
                  end
                  rd_ptr = (rd_ptr + s) % cap;
                  answers_due.push_back(pack_rsp(srb_pkg::RES_SAMPLE, word, k + 1 == n,
                                                 left, (k + 1) * s));
               end
            end
         end
         srb_pkg::REQ_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            answers_due.push_back(pack_rsp(srb_pkg::RES_DONE, '0, 1'b1, 0, 0));
         end
         default: ;
      endcase
   endtask

   // True when every stored byte from the read to the write position was written at some point
   function automatic bit region_clean();
      int unsigned cap, wp, rp, fill, i;
      cap  = cap_in_use();
      wp   = wr_ptr % cap;
      rp   = rd_ptr % cap;
      fill = (wp + cap - rp) % cap;
      for (i = 0; i < fill; i++) begin
         if (!ring_seen[(rp + i) % cap]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void field_check(string field, logic [srb_pkg::SAMPLE_W-1:0] want,
                                       logic [srb_pkg::SAMPLE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Random payload helpers
   function automatic logic [srb_pkg::SAMPLE_W-1:0] any_data();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [srb_pkg::LIMIT_W-1:0] any_limit();
      return srb_pkg::LIMIT_W'($urandom_range(16'hFFFF));
   endfunction

   // Drive side: new item or gap at the falling edge, result-side ready too
   always @(negedge clock) begin : feed
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Sample side: take accepted requests into the ring image, check each result item
   always @(posedge clock) begin : watch
      srb_pkg::rsp_item_type want;
      req_fire <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         ring_apply(req_data);
         items_taken++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (answers_due.size() == 0) begin
            $error("result item with none due: code %0d", rsp_data.result_code);
            fail_count++;
         end else begin
            want = answers_due.pop_front();
            field_check("result_code", srb_pkg::SAMPLE_W'(want.result_code),
                        srb_pkg::SAMPLE_W'(rsp_data.result_code));
            field_check("read_sample", want.read_sample, rsp_data.read_sample);
            field_check("last", srb_pkg::SAMPLE_W'(want.last),
                        srb_pkg::SAMPLE_W'(rsp_data.last));
            field_check("fill_bytes", srb_pkg::SAMPLE_W'(want.fill_bytes),
                        srb_pkg::SAMPLE_W'(rsp_data.fill_bytes));
            field_check("bytes_read_total", srb_pkg::SAMPLE_W'(want.bytes_read_total),
                        srb_pkg::SAMPLE_W'(rsp_data.bytes_read_total));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic void queue_req(logic [srb_pkg::REQ_TYPE_W-1:0] kind,
                                     logic [srb_pkg::SAMPLE_W-1:0] data,
                                     logic [srb_pkg::LIMIT_W-1:0] limit);
      srb_pkg::req_item_type item;
      item.req_type         = kind;
      item.sample_data      = data;
      item.read_limit_bytes = limit;
      req_backlog.push_back(item);
      items_queued++;
   endfunction

   // Wait until every item is taken and every result item is in, then let it settle
   task automatic wait_drained();
      while (items_taken != items_queued || answers_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(srb_pkg::csr_index_type idx,
                            logic [srb_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == srb_pkg::CSR_SAMPLE_BYTES) sample_reg = value[srb_pkg::SAMPLE_CFG_W-1:0];
      else cap_reg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic begin_phase(logic [srb_pkg::CSR_DATA_W-1:0] sample_raw,
                              logic [srb_pkg::CSR_DATA_W-1:0] cap_raw);
      csr_write(srb_pkg::CSR_SAMPLE_BYTES, sample_raw);
      csr_write(srb_pkg::CSR_CAPACITY_BYTES, cap_raw);
      // a new capacity can expose bytes never written: start empty then
      if (!region_clean()) queue_req(srb_pkg::REQ_CLEAR, any_data(), any_limit());
   endtask

   function automatic logic [srb_pkg::LIMIT_W-1:0] read_limit(int unsigned s);
      case ($urandom_range(5))
         0:       return srb_pkg::LIMIT_W'($urandom_range(s - 1));
         1, 2:    return srb_pkg::LIMIT_W'(s * $urandom_range(1, 4));
         3:       return srb_pkg::LIMIT_W'($urandom_range(70));
         4:       return any_limit();
         default: return '1;
      endcase
   endfunction

   // Mostly writes and reads with random content, runs of writes to reach full, some clears and ignored codes
   task automatic queue_random(int count);
      int made, pick, burst, j;
      int unsigned s, cap;
      made = 0;
      s    = sample_in_use();
      cap  = cap_in_use();
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            burst = $urandom_range(1, 2 * cap / s + 2);
            if (burst > 80) burst = 80;
            if (burst > count - made) burst = count - made;
            for (j = 0; j < burst; j++) begin
               queue_req(srb_pkg::REQ_WRITE, any_data(), any_limit());
            end
            made += burst;
         end else if (pick < 50) begin
            queue_req(srb_pkg::REQ_WRITE, any_data(), any_limit());
            made++;
         end else if (pick < 88) begin
            queue_req(srb_pkg::REQ_READ, any_data(), read_limit(s));
            made++;
         end else if (pick < 94) begin
            queue_req(srb_pkg::REQ_CLEAR, any_data(), any_limit());
            made++;
         end else begin
            queue_req(REQ_UNKNOWN, any_data(), any_limit());
            made++;
         end
      end
   endtask

   initial begin : stimulus
      int j;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: one-byte samples, full 1024-byte ring
      queue_req(srb_pkg::REQ_READ, '1, 16'hFFFF);          // empty ring
      queue_req(srb_pkg::REQ_WRITE, '1, 16'h0000);
      queue_req(srb_pkg::REQ_WRITE, '0, 16'hFFFF);
      queue_req(REQ_UNKNOWN, '1, 16'hFFFF);                // ignored, no result
      queue_req(srb_pkg::REQ_READ, '0, 16'd0);             // limit below one sample
      queue_req(srb_pkg::REQ_READ, '0, 16'd1);
      queue_req(srb_pkg::REQ_READ, '1, 16'hFFFF);
      queue_req(srb_pkg::REQ_WRITE, 64'hA5, 16'd0);
      queue_req(srb_pkg::REQ_CLEAR, '0, 16'd0);
      queue_req(srb_pkg::REQ_READ, '0, 16'd1);
      wait_drained();

      // Eight-byte samples in a 16-byte ring: second write refused, wrap at the end
      begin_phase(11'd8, 11'd16);
      queue_req(srb_pkg::REQ_WRITE, '1, 16'd0);
      queue_req(srb_pkg::REQ_WRITE, 64'h0123_4567_89AB_CDEF, 16'd0);
      queue_req(srb_pkg::REQ_READ, '0, 16'd7);             // one byte short of a sample
      queue_req(srb_pkg::REQ_READ, '0, 16'd8);
      queue_req(srb_pkg::REQ_WRITE, 64'hFEDC_BA98_7654_3210, 16'd0);
      queue_req(srb_pkg::REQ_READ, '0, 16'd16);
      wait_drained();

      // Registers below range: sample size 0 acts as 1, capacity 1 as 2
      begin_phase(11'h7F0, 11'd1);
      queue_req(srb_pkg::REQ_WRITE, '1, 16'd0);
      queue_req(srb_pkg::REQ_WRITE, '0, 16'd0);
      queue_req(srb_pkg::REQ_READ, '0, 16'hFFFF);
      queue_req(srb_pkg::REQ_READ, '0, 16'hFFFF);
      wait_drained();

      // Registers above range saturate to 8 bytes and 1024
      begin_phase(11'd15, 11'h7FF);
      queue_req(srb_pkg::REQ_WRITE, any_data(), 16'd0);
      queue_req(srb_pkg::REQ_READ, '0, 16'hFFFF);
      queue_req(srb_pkg::REQ_CLEAR, '1, 16'hFFFF);
      wait_drained();

      // Long read: 66 samples stored, one read stops at the per-request cap
      begin_phase(11'd8, 11'd1024);
      queue_req(srb_pkg::REQ_CLEAR, '0, 16'd0);
      for (j = 0; j < 66; j++) begin
         queue_req(srb_pkg::REQ_WRITE, any_data(), any_limit());
      end
      queue_req(srb_pkg::REQ_READ, any_data(), 16'hFFFF);
      queue_random(15);
      wait_drained();

      // Smaller capacity than the positions left behind; no idling on either side
      steady = 1'b1;
      begin_phase(11'd1, 11'd128);
      queue_random(35);
      wait_drained();
      steady = 1'b0;

      // Capacities that are a multiple of the sample size or not
      begin_phase(11'd3, 11'd30);
      queue_random(25);
      wait_drained();
      begin_phase(11'd5, 11'd40);
      queue_random(25);
      wait_drained();
      begin_phase(11'd2, 11'd16);
      queue_random(25);
      wait_drained();
      // ring too small for any sample
      begin_phase(11'd4, 11'd2);
      queue_random(10);
      wait_drained();
      begin_phase(11'd7, 11'd64);
      queue_random(25);
      wait_drained();
      for (j = 0; j < 2; j++) begin
         begin_phase(srb_pkg::CSR_DATA_W'($urandom_range(11'h7FF)),
                     srb_pkg::CSR_DATA_W'($urandom_range(2, 80)));
         queue_random(15);
         wait_drained();
      end
      begin_phase(11'd1, 11'd1024);
      queue_random(25);
      wait_drained();

      if (fail_count == 0 && answers_due.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/srb_pkg.sv
rtl/srb_ram.sv
rtl/srb_mod.sv
rtl/srb_datapath.sv
rtl/srb_ctrl.sv
rtl/sample_ring_buffer.sv
bench/sample_ring_buffer_test.sv
